// ----- rtl/dfpp_pkg.sv -----
// ----------------------------------------------------------------------------
// dfpp_pkg - shared types and constants of the decimal fixed-point parser
// Holds the word types of both channels, the parse state, the phase codes
// and the power-of-ten table used to scale a short fraction part.
// ----------------------------------------------------------------------------
package dfpp_pkg;

  localparam int CHAR_W  = 8;
  localparam int VALUE_W = 28;
  localparam int CNT_W   = 4;
  localparam int SCALE_W = 3;

  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

  typedef enum logic [2:0] {
    PH_START = 3'd0,
    PH_INT   = 3'd1,
    PH_FRAC  = 3'd2,
    PH_DONE  = 3'd3,
    PH_ERR   = 3'd4
  } phase_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              has_char;
    logic              is_last;
  } in_word_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      format_error;
  } out_word_t;

  typedef struct packed {
    phase_t             phase;
    logic               negative;
    logic [VALUE_W-1:0] acc;
    logic [CNT_W-1:0]   cnt;
    logic               seen_any;
  } parse_state_t;

  localparam parse_state_t STATE_RESET = '{
    phase:    PH_START,
    negative: 1'b0,
    acc:      '0,
    cnt:      '0,
    seen_any: 1'b0
  };

  function automatic logic [VALUE_W-1:0] pow10(input logic [SCALE_W-1:0] k);
    logic [VALUE_W-1:0] p;
    unique case (k)
      3'd0:    p = 28'd1;
      3'd1:    p = 28'd10;
      3'd2:    p = 28'd100;
      3'd3:    p = 28'd1000;
      3'd4:    p = 28'd10000;
      default: p = 28'd1;
    endcase
    return p;
  endfunction

endpackage

// ----- rtl/decimal_fixed_point_parser_top.sv -----
// ----------------------------------------------------------------------------
// decimal_fixed_point_parser_top - decimal string to fixed-point parser
// Parses a decimal string one character per word into a signed value scaled
// by ten to the number of fraction digits.
// ----------------------------------------------------------------------------
// Usage:
// The input channel takes one character word per cycle while in_stall is
// low (in_valid, in_stall, in_data). A word with is_last set closes the
// string and produces exactly one result word on the output channel
// (out_valid, out_stall, out_data); other words produce nothing. A word is
// first captured in an input register; from there it runs the character
// step and, for a last word, loads the result register, which drives the
// output channel. Throughput is one word per cycle while nothing stalls,
// set by the single pass through the step logic and the scaling multiplier.
// While a result waits under out_stall, words that produce no result keep
// flowing; a further last word waits in the input register and in_stall
// rises. Reset empties both registers and returns the parse state to the
// start of a string.
// ----------------------------------------------------------------------------
module decimal_fixed_point_parser_top #(
  parameter int INT_DIGITS  = 6,
  parameter int FRAC_DIGITS = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  dfpp_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output dfpp_pkg::out_word_t out_data
);

  dfpp_pkg::in_word_t     in_data_r;
  logic                   in_vld_r;
  logic                   in_vld_nxt;
  dfpp_pkg::parse_state_t st_r;
  dfpp_pkg::parse_state_t st_nxt;
  dfpp_pkg::parse_state_t st_step;
  dfpp_pkg::out_word_t    res;
  dfpp_pkg::out_word_t    out_data_r;
  logic                   out_vld_r;
  logic                   out_vld_nxt;
  logic                   advance;
  logic                   in_take;

  dfpp_step #(
    .INT_DIGITS  (INT_DIGITS),
    .FRAC_DIGITS (FRAC_DIGITS)
  ) u_step (
    .cur       (st_r),
    .char_code (in_data_r.char_code),
    .has_char  (in_data_r.has_char),
    .nxt       (st_step)
  );

  dfpp_final #(
    .FRAC_DIGITS (FRAC_DIGITS)
  ) u_final (
    .st  (st_step),
    .res (res)
  );

  assign advance  = in_vld_r && (!in_data_r.is_last || !out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !advance;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    in_vld_nxt = in_take ? 1'b1 : (advance ? 1'b0 : in_vld_r);
    st_nxt     = st_r;
    if (advance) begin
      st_nxt = in_data_r.is_last ? dfpp_pkg::STATE_RESET : st_step;
    end
    out_vld_nxt = out_vld_r && out_stall;
    if (advance && in_data_r.is_last) begin
      out_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      st_r      <= dfpp_pkg::STATE_RESET;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
      st_r      <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_data_r <= in_data;
    end
    if (advance && in_data_r.is_last) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

endmodule

// ----- rtl/dfpp_step.sv -----
// ----------------------------------------------------------------------------
// dfpp_step - one character step of the parser
// Takes the current parse state and one character and gives the state that
// follows: phase transition, sign flag, digit count and accumulate by ten plus digit.
// ----------------------------------------------------------------------------
module dfpp_step #(
  parameter int INT_DIGITS  = 6,
  parameter int FRAC_DIGITS = 2
) (
  input  dfpp_pkg::parse_state_t      cur,
  input  logic [dfpp_pkg::CHAR_W-1:0] char_code,
  input  logic                        has_char,
  output dfpp_pkg::parse_state_t      nxt
);

  logic                         is_dig;
  logic [3:0]                   dig_val;
  logic [dfpp_pkg::CHAR_W-1:0]  dig_diff;
  logic [dfpp_pkg::VALUE_W-1:0] acc_mac;

  assign is_dig   = (char_code >= dfpp_pkg::CH_ZERO) && (char_code <= dfpp_pkg::CH_NINE);
  assign dig_diff = char_code - dfpp_pkg::CH_ZERO;
  assign dig_val  = dig_diff[3:0];
  assign acc_mac  = (cur.acc << 3) + (cur.acc << 1)
                  + {{(dfpp_pkg::VALUE_W-4){1'b0}}, dig_val};

  always_comb begin
    nxt = cur;
    if (has_char) begin
      unique case (cur.phase)
        dfpp_pkg::PH_START: begin
          priority if (char_code == dfpp_pkg::CH_MINUS) begin
            nxt.negative = 1'b1;
            nxt.phase    = dfpp_pkg::PH_INT;
          end else if (is_dig) begin
            nxt.acc      = {{(dfpp_pkg::VALUE_W-4){1'b0}}, dig_val};
            nxt.cnt      = dfpp_pkg::CNT_W'(1);
            nxt.seen_any = 1'b1;
            nxt.phase    = dfpp_pkg::PH_INT;
          end else if (char_code == dfpp_pkg::CH_POINT) begin
            nxt.cnt      = '0;
            nxt.seen_any = 1'b1;
            nxt.phase    = dfpp_pkg::PH_FRAC;
          end else begin
            nxt.phase = dfpp_pkg::PH_ERR;
          end
        end
        dfpp_pkg::PH_INT: begin
          priority if (is_dig) begin
            if (cur.cnt < dfpp_pkg::CNT_W'(INT_DIGITS)) begin
              nxt.acc      = acc_mac;
              nxt.cnt      = cur.cnt + dfpp_pkg::CNT_W'(1);
              nxt.seen_any = 1'b1;
            end else begin
              nxt.phase = dfpp_pkg::PH_ERR;
            end
          end else if (char_code == dfpp_pkg::CH_POINT) begin
            nxt.cnt      = '0;
            nxt.seen_any = 1'b1;
            nxt.phase    = dfpp_pkg::PH_FRAC;
          end else begin
            nxt.phase = dfpp_pkg::PH_ERR;
          end
        end
        dfpp_pkg::PH_FRAC: begin
          priority if (is_dig) begin
            if (cur.cnt < dfpp_pkg::CNT_W'(FRAC_DIGITS)) begin
              nxt.acc = acc_mac;
              nxt.cnt = cur.cnt + dfpp_pkg::CNT_W'(1);
            end else begin
              nxt.phase = dfpp_pkg::PH_ERR;
            end
          end else if (char_code == dfpp_pkg::CH_NUL) begin
            nxt.phase = dfpp_pkg::PH_DONE;
          end else begin
            nxt.phase = dfpp_pkg::PH_ERR;
          end
        end
        default: begin
          nxt = cur;
        end
      endcase
    end
  end

endmodule

// ----- rtl/dfpp_final.sv -----
// ----------------------------------------------------------------------------
// dfpp_final - end-of-string evaluation
// Decides whether the string was well formed, scales the gathered digits to
// the full fraction width and applies the sign.
// ----------------------------------------------------------------------------
module dfpp_final #(
  parameter int FRAC_DIGITS = 2
) (
  input  dfpp_pkg::parse_state_t st,
  output dfpp_pkg::out_word_t    res
);

  logic                          err;
  logic [dfpp_pkg::CNT_W-1:0]    frac_have;
  logic [dfpp_pkg::CNT_W-1:0]    missing;
  logic [2*dfpp_pkg::VALUE_W-1:0] prod;
  logic [dfpp_pkg::VALUE_W-1:0]  mag;

  assign err = (st.phase == dfpp_pkg::PH_ERR) || (st.phase == dfpp_pkg::PH_START)
            || ((st.phase == dfpp_pkg::PH_INT) && !st.seen_any);
  assign frac_have = (st.phase == dfpp_pkg::PH_INT) ? '0 : st.cnt;
  assign missing   = dfpp_pkg::CNT_W'(FRAC_DIGITS) - frac_have;
  assign prod      = st.acc * dfpp_pkg::pow10(missing[dfpp_pkg::SCALE_W-1:0]);
  assign mag       = prod[dfpp_pkg::VALUE_W-1:0];

  always_comb begin
    res.format_error = err;
    if (err) begin
      res.value = '0;
    end else if (st.negative) begin
      res.value = $signed(-mag);
    end else begin
      res.value = $signed(mag);
    end
  end

endmodule

// ----- rtl/dfpp_checker.sv -----
// ----------------------------------------------------------------------------
// dfpp_checker - port-level checks of the decimal fixed-point parser
// Watches the top-level ports for result hold, error encoding and the
// state of both channels after reset.
// ----------------------------------------------------------------------------
module dfpp_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input dfpp_pkg::out_word_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("Stalled result word changed or dropped.");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.format_error |-> out_data.value == '0)
    else $error("Error result carries a nonzero value.");

  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("Result word valid right after reset.");

  a_rst_in: assert property (@(posedge clk) !rst_n |=> !in_stall)
    else $error("Input stalled right after reset.");

endmodule

bind decimal_fixed_point_parser_top dfpp_checker u_dfpp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
